// File: rtl/core/aenc_pkg.sv
// ----------------------------------------------------------------------------
// aenc_pkg
// Shared constants, codes and stage payload types of the audio sample encoder.
// ----------------------------------------------------------------------------
package aenc_pkg;

    // encoding modes
    localparam logic [1:0] MODE_MULAW = 2'd0;
    localparam logic [1:0] MODE_PCM8  = 2'd1;
    localparam logic [1:0] MODE_PCM16 = 2'd2;

    // configuration register indexes
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    // unity gain, Q1.16
    localparam logic [16:0] GAIN_ONE = 17'd65536;

    // output scale coefficients (PCM ones carry a factor of 1000)
    localparam logic [24:0] COEF_MULAW = 25'd8158;
    localparam logic [24:0] COEF_PCM8  = 25'd127444;
    localparam logic [24:0] COEF_PCM16 = 25'd32767444;

    // saturation limits
    localparam logic [25:0] LIM_MULAW = 26'd8158;
    localparam logic [25:0] LIM_PCM8  = 26'd127;
    localparam logic [25:0] LIM_PCM16 = 26'd32767;

    // divide by 1000: q = (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 2^25
    localparam logic [25:0] RECIP_1000  = 26'd34359739;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [10:0] PCM_DIV     = 11'd1000;
    localparam logic [10:0] MULAW_DIV   = 11'd1;

    // mu-law segment bias
    localparam logic [12:0] MULAW_BIAS = 13'd33;

    // product stage payload
    typedef struct packed {
        logic [1:0]  mode;
        logic        neg;
        logic [56:0] prod;
    } prod_t;

    // rounded and saturated magnitude
    typedef struct packed {
        logic [1:0]  mode;
        logic        neg;
        logic [14:0] mag;
    } rnd_t;

    function automatic logic [24:0] mode_coef(input logic [1:0] mode);
        logic [24:0] c;
        c = '0;
        unique case (mode)
            MODE_MULAW: c = COEF_MULAW;
            MODE_PCM8:  c = COEF_PCM8;
            MODE_PCM16: c = COEF_PCM16;
            default:    c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/aenc_scale.sv
// ----------------------------------------------------------------------------
// aenc_scale
// Three pipeline stages: sample magnitude, gain product, coefficient product.
// ----------------------------------------------------------------------------
module aenc_scale (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          in_sample,
    input  logic [1:0]           in_mode,
    input  logic [16:0]          in_gain,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aenc_pkg::prod_t      out_data
);
    import aenc_pkg::*;

    logic        va_reg, vb_reg, vc_reg;
    logic        en_a, en_b, en_c;
    logic [16:0] mag_reg;
    logic [16:0] gain_reg;
    logic        nega_reg, negb_reg;
    logic [1:0]  modea_reg, modeb_reg;
    logic [31:0] p_reg;
    prod_t       out_reg;
    logic [16:0] mag_next;
    logic [33:0] p_full;
    logic [56:0] n_next;

    // stage enables: a stage loads when empty or when its successor loads
    assign en_c = !vc_reg || out_ready;
    assign en_b = !vb_reg || en_c;
    assign en_a = !va_reg || en_b;
    assign in_ready = en_a;

    assign mag_next = in_sample[15] ? (17'd0 - {in_sample[15], in_sample})
                                    : {1'b0, in_sample};
    assign p_full = mag_reg * gain_reg;
    assign n_next = p_reg * mode_coef(modeb_reg);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en_a) begin
            mag_reg   <= mag_next;
            gain_reg  <= in_gain;
            nega_reg  <= in_sample[15];
            modea_reg <= in_mode;
        end
        if (en_b) begin
            p_reg     <= p_full[31:0];
            negb_reg  <= nega_reg;
            modeb_reg <= modea_reg;
        end
        if (en_c) begin
            out_reg.prod <= n_next;
            out_reg.neg  <= negb_reg;
            out_reg.mode <= modeb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/core/aenc_round.sv
// ----------------------------------------------------------------------------
// aenc_round
// Two stages: scale-down by 2^30 (and 1000 for PCM), then half-to-even
// rounding and saturation to the mode's limit.
// ----------------------------------------------------------------------------
module aenc_round (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aenc_pkg::prod_t      in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aenc_pkg::rnd_t       out_data
);
    import aenc_pkg::*;

    logic        vd_reg, ve_reg;
    logic        en_d, en_e;
    logic [24:0] q_reg, hic_reg;
    logic        half_reg, lownz_reg, negd_reg;
    logic [1:0]  moded_reg;
    rnd_t        out_reg;

    logic [26:0] hi;
    logic [24:0] hi_c;
    logic [50:0] qprod;
    logic [24:0] q_next;
    logic [25:0] qmul;
    logic [9:0]  r1;
    logic [10:0] t, dv;
    logic        inc;
    logic [25:0] qt, lim, sat;
    logic        mu;

    assign en_e = !ve_reg || out_ready;
    assign en_d = !vd_reg || en_e;
    assign in_ready = en_d;

    // stage D: integer part above 2^30, clamp, reciprocal divide by 1000
    assign hi    = in_data.prod[56:30];
    assign hi_c  = (hi[26:25] != 2'b00) ? '1 : hi[24:0];
    assign qprod = hi_c * RECIP_1000;
    assign q_next = (in_data.mode == MODE_MULAW) ? hi_c
                                                 : {9'd0, qprod[50:RECIP_SHIFT]};

    // stage E: remainder, half-to-even increment, saturation
    assign mu   = (moded_reg == MODE_MULAW);
    assign qmul = q_reg[15:0] * 10'd1000;
    assign r1   = mu ? 10'd0 : (hic_reg[9:0] - qmul[9:0]);
    assign t    = {r1, half_reg};
    assign dv   = mu ? MULAW_DIV : PCM_DIV;
    assign inc  = (t > dv) || ((t == dv) && (lownz_reg || q_reg[0]));
    assign qt   = {1'b0, q_reg} + {25'd0, inc};

    always_comb begin
        unique case (moded_reg)
            MODE_MULAW: lim = LIM_MULAW;
            MODE_PCM8:  lim = LIM_PCM8;
            MODE_PCM16: lim = LIM_PCM16;
            default:    lim = '0;
        endcase
    end
    assign sat = (qt > lim) ? lim : qt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (en_d) vd_reg <= in_valid;
            if (en_e) ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            q_reg     <= q_next;
            hic_reg   <= hi_c;
            half_reg  <= in_data.prod[29];
            lownz_reg <= (in_data.prod[28:0] != '0);
            negd_reg  <= in_data.neg;
            moded_reg <= in_data.mode;
        end
        if (en_e) begin
            out_reg.mag  <= sat[14:0];
            // a value that rounds to zero is positive zero
            out_reg.neg  <= negd_reg && (sat != '0);
            out_reg.mode <= moded_reg;
        end
    end

    assign out_valid = ve_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/core/aenc_pack.sv
// ----------------------------------------------------------------------------
// aenc_pack
// Output stage: mu-law segment/mantissa packing or two's complement PCM,
// held in the output register until taken.
// ----------------------------------------------------------------------------
module aenc_pack (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aenc_pkg::rnd_t       in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          out_code
);
    import aenc_pkg::*;

    logic        vf_reg;
    logic        en_f;
    logic [15:0] code_reg;
    logic [15:0] code_next;
    logic [12:0] b;
    logic [3:0]  top_bit;
    logic [3:0]  seg_w;
    logic [2:0]  seg;
    logic [12:0] shifted;
    logic [7:0]  mu_code;
    logic [15:0] signed_val;

    assign en_f = !vf_reg || out_ready;
    assign in_ready = en_f;

    // biased magnitude and its leading one picks the segment
    assign b = in_data.mag[12:0] + MULAW_BIAS;
    always_comb begin
        top_bit = 4'd5;
        for (int i = 5; i < 13; i++) begin
            if (b[i]) top_bit = 4'(i);
        end
    end
    assign seg_w   = top_bit - 4'd5;
    assign seg     = seg_w[2:0];
    assign shifted = b >> ({1'b0, seg} + 4'd1);
    assign mu_code = ~{in_data.neg, seg, shifted[3:0]};

    assign signed_val = in_data.neg ? (16'd0 - {1'b0, in_data.mag}) : {1'b0, in_data.mag};

    always_comb begin
        unique case (in_data.mode)
            MODE_MULAW: code_next = {8'd0, mu_code};
            MODE_PCM8:  code_next = {8'd0, signed_val[7:0]};
            MODE_PCM16: code_next = signed_val;
            default:    code_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (en_f) begin
            vf_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_f) code_reg <= code_next;
    end

    assign out_valid = vf_reg;
    assign out_code  = code_reg;

endmodule

// File: rtl/core/audio_sample_encoder.sv
// ----------------------------------------------------------------------------
// audio_sample_encoder
// Sample stream to mu-law, 8-bit or 16-bit PCM codes with a programmable gain.
// ----------------------------------------------------------------------------
// The encoder takes one Q2.14 sample per clock unless the output stalls and
// returns one code per sample through a six-stage pipeline (magnitude,
// gain multiply, coefficient multiply, reciprocal divide, round/saturate,
// pack). Each stage holds its own valid bit, so bubbles fill while the output
// is stalled and s_tready falls only when every stage holds a sample. Gain
// (scale_factor / 65536, above one treated as one) and encoding_mode are set
// through the write port and must be changed only while no sample is in
// flight. Mode 3 yields a zero code.
module audio_sample_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [16:0] cfg_wdata,
    // sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample_in
    // code output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [15:0] code_out
);
    import aenc_pkg::*;

    logic [1:0]  mode_reg;
    logic [16:0] scale_reg;
    logic [16:0] gain;

    logic        sc_valid, sc_ready;
    prod_t       sc_data;
    logic        rd_valid, rd_ready;
    rnd_t        rd_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_MULAW;
            scale_reg <= GAIN_ONE;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MODE:  mode_reg  <= cfg_wdata[1:0];
                REG_SCALE: scale_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // gain above unity acts as unity
    assign gain = (scale_reg > GAIN_ONE) ? GAIN_ONE : scale_reg;

    aenc_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata),
        .in_mode   (mode_reg),
        .in_gain   (gain),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_data  (sc_data)
    );

    aenc_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .in_data   (sc_data),
        .out_valid (rd_valid),
        .out_ready (rd_ready),
        .out_data  (rd_data)
    );

    aenc_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid),
        .in_ready  (rd_ready),
        .in_data   (rd_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (m_tdata)
    );

endmodule

// File: rtl/core/aenc_checker.sv
// ----------------------------------------------------------------------------
// aenc_checker
// Port-level checks of the audio sample encoder, bound to the top level.
// ----------------------------------------------------------------------------
module aenc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_we,
    input logic        cfg_addr,
    input logic [16:0] cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import aenc_pkg::*;

    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic [1:0] mode_reg;
    logic       in_beat, out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // samples accepted and not yet delivered
    always_comb begin
        pend_next = pend_reg;
        if (in_beat && !out_beat) pend_next = pend_reg + 3'd1;
        if (!in_beat && out_beat) pend_next = pend_reg - 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            mode_reg <= MODE_MULAW;
        end else begin
            pend_reg <= pend_next;
            if (cfg_we && cfg_addr == REG_MODE) mode_reg <= cfg_wdata[1:0];
        end
    end

    // no code without a pending sample
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 3'd0)
        else $error("code beat without a pending sample");

    // at most six samples in flight
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == 3'd6 |-> !(in_beat && !out_beat))
        else $error("more samples in flight than pipeline stages");

    // byte-wide modes leave the upper byte clear
    a_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mode_reg != MODE_PCM16 |-> m_tdata[15:8] == 8'd0)
        else $error("upper code byte set in a byte-wide mode");

    // stalled code beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled code beat changed");

endmodule

bind audio_sample_encoder aenc_checker u_aenc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the audio sample encoder. A directed table covers
// reset values, full-scale and overdriven samples, gain extremes, the unused
// mode and rounding near zero. Random phases then follow, each under its own
// mode and gain setting. Every code beat is compared with a pinned code or a
// bit-exact integer predictor. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module testbench;

    import aenc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // predictor constants: output peak and coefficient per mode
    localparam longint unsigned MULAW_PEAK  = 64'd8158;
    localparam longint unsigned PCM8_COEF   = 64'd127444;
    localparam longint unsigned PCM16_COEF  = 64'd32767444;
    localparam longint unsigned PCM8_PEAK   = 64'd127;
    localparam longint unsigned PCM16_PEAK  = 64'd32767;
    localparam longint unsigned UNITY_GAIN  = 64'd65536;
    localparam longint unsigned SEG_BIAS    = 64'd33;

    localparam int DIR_ROWS    = 24;
    localparam int PHASES      = 12;
    localparam int PHASE_BEATS = 90;
    localparam int PIPE_SLACK  = 10;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_addr;
    logic [16:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    // settings currently held by the block
    logic [1:0]  cur_mode;
    logic [16:0] cur_gain;

    logic [15:0] pending_codes[$];
    int          mismatch_count;
    int          src_run;
    int          sink_run;

    // directed table: pinned rows carry a code read straight off the spec
    typedef struct packed {
        logic [1:0]  mode;
        logic [16:0] gain;
        logic [15:0] smp;
        logic        pinned;
        logic [15:0] code;
    } dir_row_t;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{MODE_MULAW,  17'd65536,  16'h0000, 1'b1, 16'h00FF},  // reset setting
        '{MODE_MULAW,  17'd65536,  16'h4000, 1'b1, 16'h0080},
        '{MODE_MULAW,  17'd65536,  16'hC000, 1'b1, 16'h0000},
        '{MODE_MULAW,  17'd65536,  16'h7FFF, 1'b1, 16'h0080},
        '{MODE_MULAW,  17'd65536,  16'h8000, 1'b1, 16'h0000},
        '{MODE_MULAW,  17'd65536,  16'hFFFF, 1'b1, 16'h00FF},  // -0 -> +0
        '{MODE_MULAW,  17'd65536,  16'hFFFE, 1'b0, 16'h0000},
        '{MODE_MULAW,  17'd65536,  16'h1000, 1'b0, 16'h0000},  // exact tie
        '{MODE_MULAW,  17'd65536,  16'h0001, 1'b0, 16'h0000},
        '{MODE_MULAW,  17'd131071, 16'h4000, 1'b1, 16'h0080},  // gain > 1
        '{MODE_MULAW,  17'd65537,  16'h8000, 1'b1, 16'h0000},
        '{MODE_MULAW,  17'd0,      16'h7FFF, 1'b1, 16'h00FF},  // zero gain
        '{MODE_MULAW,  17'd0,      16'h8000, 1'b1, 16'h00FF},
        '{MODE_PCM8,   17'd65536,  16'h4000, 1'b1, 16'h007F},
        '{MODE_PCM8,   17'd65536,  16'h8000, 1'b1, 16'h0081},
        '{MODE_PCM8,   17'd65536,  16'hFFFF, 1'b1, 16'h0000},
        '{MODE_PCM8,   17'd32768,  16'h1234, 1'b0, 16'h0000},
        '{MODE_PCM16,  17'd65536,  16'h4000, 1'b1, 16'h7FFF},
        '{MODE_PCM16,  17'd65536,  16'hC000, 1'b1, 16'h8001},
        '{MODE_PCM16,  17'd65536,  16'h7FFF, 1'b1, 16'h7FFF},
        '{MODE_PCM16,  17'd1,      16'h7FFF, 1'b0, 16'h0000},
        '{MODE_PCM16,  17'd65535,  16'h2000, 1'b0, 16'h0000},
        '{MODE_UNUSED, 17'd65536,  16'h7FFF, 1'b1, 16'h0000},
        '{MODE_UNUSED, 17'd0,      16'h8000, 1'b1, 16'h0000}
    };

    audio_sample_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // bit-exact code for one sample under the given mode and gain register
    function automatic logic [15:0] encode_sample(input logic [1:0] mode,
                                                  input logic [16:0] gain_reg,
                                                  input logic [15:0] smp);
        longint unsigned mag, gain, coef, den, peak, num, quo, rem, biased;
        logic            neg;
        logic [2:0]      seg;
        int              k;
        neg  = smp[15];
        mag  = neg ? (64'd65536 - 64'(smp)) : 64'(smp);
        gain = (64'(gain_reg) > UNITY_GAIN) ? UNITY_GAIN : 64'(gain_reg);
        case (mode)
            MODE_MULAW: begin
                coef = MULAW_PEAK;
                den  = 64'd1 << 30;
                peak = MULAW_PEAK;
            end
            MODE_PCM8: begin
                coef = PCM8_COEF;
                den  = 64'd1000 << 30;
                peak = PCM8_PEAK;
            end
            MODE_PCM16: begin
                coef = PCM16_COEF;
                den  = 64'd1000 << 30;
                peak = PCM16_PEAK;
            end
            default: begin
                return 16'h0000;
            end
        endcase
        // round half-to-even on the magnitude, then saturate
        num = mag * gain * coef;
        quo = num / den;
        rem = num % den;
        if ((2 * rem > den) || ((2 * rem == den) && quo[0]))
            quo = quo + 1;
        if (quo > peak)
            quo = peak;
        if (quo == 0)
            neg = 1'b0;
        case (mode)
            MODE_MULAW: begin
                // segment is the octave of the biased magnitude above 64
                biased = quo + SEG_BIAS;
                seg    = 3'd0;
                for (k = 0; k < 7; k++)
                    if (biased >= (64'd64 << k))
                        seg = 3'(k + 1);
                return {8'h00, ~{neg, seg, 4'(biased >> (seg + 1))}};
            end
            MODE_PCM8: begin
                return {8'h00, 8'(neg ? -quo : quo)};
            end
            default: begin
                return 16'(neg ? -quo : quo);
            end
        endcase
    endfunction

    // idle cycles before the next beat, with occasional stretches of none
    function automatic int draw_gap(inout int run);
        if (run == 0 && $urandom_range(0, 15) == 0)
            run = $urandom_range(8, 40);
        if (run > 0) begin
            run--;
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // random sample biased toward zero, full scale and segment edges
    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 65535);
            4, 5:       v = $urandom_range(0, 255) - 128;
            6, 7:       v = ($urandom_range(0, 1) ? 16384 : -16384)
                            + $urandom_range(0, 511) - 256;
            8: begin
                case ($urandom_range(0, 6))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0000;
                    3: v = 16'hFFFF;
                    4: v = 16'h0001;
                    5: v = 16'h4000;
                    default: v = 16'hC000;
                endcase
            end
            default: begin
                v = (1 << $urandom_range(0, 14)) + $urandom_range(0, 7) - 4;
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return 16'(v);
    endfunction

    function automatic logic [16:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'd131071;
            3: return 17'($urandom_range(65537, 131071));
            4: return 17'($urandom_range(1, 65535));
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    // send one sample beat and queue its expected code on acceptance
    task automatic send_sample(input logic [15:0] smp, input logic pinned,
                               input logic [15:0] pinned_code);
        int gap;
        gap = draw_gap(src_run);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_codes.push_back(pinned ? pinned_code
                                       : encode_sample(cur_mode, cur_gain, smp));
    endtask

    // stop sending and let the pipeline empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    // write both registers while the block is idle; mode gets junk upper bits
    task automatic program_block(input logic [1:0] mode, input logic [16:0] gain);
        logic [16:0] mode_word;
        drain();
        mode_word      = 17'($urandom);
        mode_word[1:0] = mode;
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MODE;
        cfg_wdata <= mode_word;
        @(posedge aclk);
        cfg_addr  <= REG_SCALE;
        cfg_wdata <= gain;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_mode = mode;
        cur_gain = gain;
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls between code beats
    initial begin
        int gap;
        m_tready <= 1'b0;
        sink_run = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap(sink_run);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // compare each code beat with the oldest expectation
    always @(posedge aclk) begin
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_codes.size() == 0) begin
                $error("code_out: no code expected, got %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_codes.pop_front();
                if (m_tdata !== want) begin
                    $error("code_out: expected %h, got %h", want, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // reset, directed table, random phases, final verdict
    initial begin
        logic [1:0]  mode;
        logic [16:0] gain;
        mismatch_count = 0;
        src_run        = 0;
        cur_mode       = MODE_MULAW;
        cur_gain       = 17'd65536;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 16'h0000;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_MODE;
        cfg_wdata <= 17'd0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows; reprogram only where the setting changes
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].mode != cur_mode || dir_tab[r].gain != cur_gain)
                program_block(dir_tab[r].mode, dir_tab[r].gain);
            send_sample(dir_tab[r].smp, dir_tab[r].pinned, dir_tab[r].code);
        end

        // random phases: fixed extremes first, then random settings
        for (int p = 0; p < PHASES; p++) begin
            if (p < 8) begin
                mode = 2'(p % 4);
            end else begin
                mode = ($urandom_range(0, 7) == 0) ? MODE_UNUSED
                                                   : 2'($urandom_range(0, 2));
            end
            case (p)
                0, 1, 2, 3: gain = 17'd65536;
                4:          gain = 17'd0;
                5:          gain = 17'd131071;
                6:          gain = 17'd1;
                7:          gain = 17'd65535;
                default:    gain = pick_gain();
            endcase
            program_block(mode, gain);
            for (int i = 0; i < PHASE_BEATS; i++)
                send_sample(pick_sample(), 1'b0, 16'h0000);
        end

        drain();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
